// ----- rtl/core/sbms_pkg.sv -----
// sbms_pkg: shared types and constants for the shared-buffer multi-stack block
// no dependencies; compiled first
package sbms_pkg;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// ----- rtl/core/sbms_if.sv -----
// sbms_in_if / sbms_out_if: valid-ready channels for command and result words
// depends on sbms_pkg
interface sbms_in_if;
  logic                                valid;
  logic                                ready;
  logic [sbms_pkg::OPCODE_W-1:0]       opcode;
  logic [sbms_pkg::SEL_W-1:0]          stack_sel;
  logic signed [sbms_pkg::DATA_W-1:0]  push_value;

  modport source (output valid, output opcode, output stack_sel, output push_value,
                  input ready);
  modport sink   (input valid, input opcode, input stack_sel, input push_value,
                  output ready);
endinterface

interface sbms_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sbms_pkg::DATA_W-1:0]  pop_value;
  logic [sbms_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

// ----- rtl/core/sbms_ram.sv -----
// sbms_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module sbms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/shared_buffer_multi_stack.sv -----
// shared_buffer_multi_stack: several LIFO stacks over one shared pool of linked cells
// depends on sbms_pkg, sbms_if (sbms_in_if, sbms_out_if) and sbms_ram

// NUM_STACKS stacks share NUM_STACKS*CELLS_PER_STACK cells held in one RAM; each
// cell keeps a value and a link to the cell below it. A push stores the value in
// a free cell and makes it the stack's head, a pop returns the head's value and
// frees the cell; a pop of an empty stack returns status 1, a push with every
// cell taken returns status 2, and neither changes anything. Every command word
// gives exactly one result word. One command is taken per clock cycle unless the
// result side is backed up, and its result is registered: the accepting cycle issues
// the RAM read of the head cell (pop) or of the next free-list cell (push), the
// execute stage then uses the registered read data to update the heads and the free
// list and loads the result register. Freed cells are kept on a linked free list,
// cells never used are handed out from a fill counter, so no clearing pass is needed
// after reset. stack_sel is taken modulo NUM_STACKS.
module shared_buffer_multi_stack #(
  parameter int unsigned NUM_STACKS      = 4,
  parameter int unsigned CELLS_PER_STACK = 64,
  parameter int unsigned VALUE_WIDTH     = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbms_in_if.sink     in_i,
  sbms_out_if.source  out_o
);

  localparam int unsigned POOL = NUM_STACKS * CELLS_PER_STACK;
  localparam int unsigned PW   = (POOL > 1) ? $clog2(POOL) : 1;
  localparam int unsigned CW   = $clog2(POOL + 1);
  localparam int unsigned SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned RW   = VALUE_WIDTH + 1 + PW;

  function automatic logic [SW-1:0] sel_map(input logic [sbms_pkg::SEL_W-1:0] sel);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << sbms_pkg::SEL_W); i++) begin
      if (sel == sbms_pkg::SEL_W'(i)) begin
        r = SW'(i % NUM_STACKS);
      end
    end
    return r;
  endfunction

  // stack heads and free list
  logic [PW-1:0]         head_q [NUM_STACKS];
  logic [NUM_STACKS-1:0] head_vld_q;
  logic [PW-1:0]         free_head_q;
  logic                  free_vld_q;
  logic [CW-1:0]         fresh_q;

  // execute stage
  logic                   e_vld_q;
  logic                   e_pop_q;
  logic                   e_list_q;
  sbms_pkg::status_e      e_status_q;
  logic [SW-1:0]          e_sel_q;
  logic [PW-1:0]          e_addr_q;
  logic [VALUE_WIDTH-1:0] e_value_q;
  logic [PW-1:0]          e_link_q;
  logic                   e_lvld_q;

  // read-during-write bypass
  logic          byp_q;
  logic [RW-1:0] byp_word_q;

  // result register
  logic                             out_vld_q;
  logic signed [sbms_pkg::DATA_W-1:0] out_value_q;
  sbms_pkg::status_e                out_status_q;

  logic                          e_adv, acc;
  logic [RW-1:0]                 ram_rdata, rword, wdata;
  logic signed [VALUE_WIDTH-1:0] r_value;
  logic                          r_lvld;
  logic [PW-1:0]                 r_link;
  logic                          commit, we;
  logic [PW-1:0]                 head_new;
  logic                          head_new_vld;
  logic [PW-1:0]                 free_head_d;
  logic                          free_vld_d;
  logic [CW-1:0]                 fresh_d;
  logic [SW-1:0]                 a_sel;
  logic                          a_hit;
  logic [PW-1:0]                 a_head;
  logic                          a_hvld;
  logic                          a_pop;
  logic                          a_list;
  logic [PW-1:0]                 a_addr;
  sbms_pkg::status_e             a_status;

  assign e_adv      = e_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !e_vld_q || e_adv;
  assign acc        = in_i.valid && in_i.ready;

  assign rword   = byp_q ? byp_word_q : ram_rdata;
  assign r_value = rword[RW-1 -: VALUE_WIDTH];
  assign r_lvld  = rword[PW];
  assign r_link  = rword[PW-1:0];

  // execute: commit the item in the stage using the read data
  always_comb begin
    commit       = e_adv && (e_status_q == sbms_pkg::ST_OK);
    we           = commit;
    head_new     = e_pop_q ? r_link : e_addr_q;
    head_new_vld = e_pop_q ? r_lvld : 1'b1;
    free_head_d  = free_head_q;
    free_vld_d   = free_vld_q;
    fresh_d      = fresh_q;
    if (e_pop_q) begin
      wdata = {r_value, free_vld_q, free_head_q};
    end else begin
      wdata = {e_value_q, e_lvld_q, e_link_q};
    end
    if (commit) begin
      if (e_pop_q) begin
        free_head_d = e_addr_q;
        free_vld_d  = 1'b1;
      end else if (e_list_q) begin
        free_head_d = r_link;
        free_vld_d  = r_lvld;
      end else begin
        fresh_d = fresh_q + CW'(1);
      end
    end
  end

  // accept: decide the address against the state as the stage leaves it
  always_comb begin
    a_sel    = sel_map(in_i.stack_sel);
    a_hit    = commit && (e_sel_q == a_sel);
    a_head   = a_hit ? head_new : head_q[a_sel];
    a_hvld   = a_hit ? head_new_vld : head_vld_q[a_sel];
    a_pop    = (in_i.opcode == sbms_pkg::OP_POP);
    a_list   = 1'b0;
    a_addr   = a_head;
    a_status = sbms_pkg::ST_OK;
    if (a_pop) begin
      if (!a_hvld) begin
        a_status = sbms_pkg::ST_EMPTY;
      end
    end else if (free_vld_d) begin
      a_list = 1'b1;
      a_addr = free_head_d;
    end else if (fresh_d < CW'(POOL)) begin
      a_addr = PW'(fresh_d);
    end else begin
      a_status = sbms_pkg::ST_FULL;
    end
  end

  sbms_ram #(
    .WIDTH (RW),
    .DEPTH (POOL)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (e_addr_q),
    .wdata_i (wdata),
    .re_i    (acc),
    .raddr_i (a_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        head_q[i] <= '0;
      end
      head_vld_q  <= '0;
      free_head_q <= '0;
      free_vld_q  <= 1'b0;
      fresh_q     <= '0;
      e_vld_q     <= 1'b0;
      byp_q       <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (commit) begin
        head_q[e_sel_q]     <= head_new;
        head_vld_q[e_sel_q] <= head_new_vld;
      end
      free_head_q <= free_head_d;
      free_vld_q  <= free_vld_d;
      fresh_q     <= fresh_d;
      if (acc) begin
        e_vld_q <= 1'b1;
        byp_q   <= we && (e_addr_q == a_addr);
      end else if (e_adv) begin
        e_vld_q <= 1'b0;
      end
      if (e_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      e_pop_q    <= a_pop;
      e_list_q   <= a_list;
      e_status_q <= a_status;
      e_sel_q    <= a_sel;
      e_addr_q   <= a_addr;
      e_value_q  <= VALUE_WIDTH'(in_i.push_value);
      e_link_q   <= a_head;
      e_lvld_q   <= a_hvld;
      byp_word_q <= wdata;
    end
    if (e_adv) begin
      out_status_q <= e_status_q;
      if (e_pop_q && (e_status_q == sbms_pkg::ST_OK)) begin
        out_value_q <= sbms_pkg::DATA_W'(r_value);
      end else begin
        out_value_q <= '0;
      end
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.pop_value = out_value_q;
  assign out_o.status    = out_status_q;

endmodule

// ----- rtl/core/sbms_checker.sv -----
// sbms_checker: port-level assertions for shared_buffer_multi_stack, with its bind
// depends on sbms_pkg and shared_buffer_multi_stack
module sbms_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic [sbms_pkg::OPCODE_W-1:0]     opcode_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [sbms_pkg::DATA_W-1:0]       pop_value_i,
  input logic [sbms_pkg::STATUS_W-1:0]     status_i
);

  logic pushed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pushed_q <= 1'b0;
    end else if (in_valid_i && in_ready_i && (opcode_i == sbms_pkg::OP_PUSH)) begin
      pushed_q <= 1'b1;
    end
  end

  // a waiting result word is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  // failed operations never carry a value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != sbms_pkg::ST_OK) |-> pop_value_i == '0)
    else $error("error result with non-zero value");

  // the block only refuses a command when the result side is backed up
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("command refused while the result side is free");

  // with no push since reset every stack is empty
  a_empty_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pushed_q |-> status_i == sbms_pkg::ST_EMPTY)
    else $error("pop succeeded with nothing pushed");

endmodule

bind shared_buffer_multi_stack sbms_checker u_sbms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .opcode_i    (in_i.opcode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pop_value_i (out_o.pop_value),
  .status_i    (out_o.status)
);

// ----- dv/tb.sv -----
// tb: self-checking bench for shared_buffer_multi_stack, pushes and pops across the stacks
// depends on sbms_pkg, sbms_in_if / sbms_out_if and the block itself
// results are predicted from a cell-pool model and compared word by word in order
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTK        = 4;
  localparam int NCELL       = NSTK * 64;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 200000;

  // idle percentages per phase: none, sender idle, receiver stalling, both
  localparam int TX_IDLE_PCT [4] = '{0, 69, 0, 25};
  localparam int RX_STALL_PCT[4] = '{0, 0, 69, 25};

  typedef struct {
    logic [sbms_pkg::OPCODE_W-1:0]      op;
    logic [sbms_pkg::SEL_W-1:0]         sel;
    logic signed [sbms_pkg::DATA_W-1:0] val;
    int                                 phase;
  } cmd_t;

  typedef struct {
    logic signed [sbms_pkg::DATA_W-1:0] value;
    sbms_pkg::status_e                  status;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                               drv_valid = 1'b0;
  logic [sbms_pkg::OPCODE_W-1:0]      drv_op    = sbms_pkg::OP_PUSH;
  logic [sbms_pkg::SEL_W-1:0]         drv_sel   = '0;
  logic signed [sbms_pkg::DATA_W-1:0] drv_val   = '0;
  logic                               rx_ready  = 1'b0;

  sbms_in_if  cmd_if ();
  sbms_out_if res_if ();

  assign cmd_if.valid      = drv_valid;
  assign cmd_if.opcode     = drv_op;
  assign cmd_if.stack_sel  = drv_sel;
  assign cmd_if.push_value = drv_val;
  assign res_if.ready      = rx_ready;

  shared_buffer_multi_stack dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  cmd_t    pending_cmds[$];
  result_t expected_results[$];
  int      n_accepted  = 0;
  int      n_errors    = 0;
  int      rx_stall_pct = 0;
  int      cycles      = 0;
  int      hold_left   = 0;
  bit      hold_done   = 1'b0;

  // predictor state: one pool of cells, a head per stack
  logic [7:0]                         head_idx [NSTK];
  bit                                 head_ok  [NSTK];
  logic signed [sbms_pkg::DATA_W-1:0] cell_val [NCELL];
  logic [7:0]                         cell_nxt [NCELL];
  bit                                 cell_nxt_ok [NCELL];
  bit                                 cell_free [NCELL];

  // stimulus-side occupancy, used only to shape sequences
  int gen_depth [NSTK];
  int gen_used = 0;

  function automatic result_t pool_apply(cmd_t c);
    result_t r;
    int      s;
    int      idx;
    r.value  = '0;
    r.status = sbms_pkg::ST_OK;
    s   = int'(c.sel) % NSTK;
    idx = -1;
    if (c.op == sbms_pkg::OP_PUSH) begin
      for (int i = 0; i < NCELL; i++) begin
        if (idx < 0 && cell_free[i]) idx = i;
      end
      if (idx < 0) begin
        r.status = sbms_pkg::ST_FULL;
      end else begin
        cell_val[idx]    = c.val;
        cell_nxt[idx]    = head_idx[s];
        cell_nxt_ok[idx] = head_ok[s];
        head_idx[s]      = idx[7:0];
        head_ok[s]       = 1'b1;
        cell_free[idx]   = 1'b0;
      end
    end else begin
      if (!head_ok[s]) begin
        r.status = sbms_pkg::ST_EMPTY;
      end else begin
        idx            = head_idx[s];
        r.value        = cell_val[idx];
        head_idx[s]    = cell_nxt[idx];
        head_ok[s]     = cell_nxt_ok[idx];
        cell_free[idx] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic signed [sbms_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(logic [sbms_pkg::OPCODE_W-1:0] op, int sel,
                         logic signed [sbms_pkg::DATA_W-1:0] val, int phase);
    cmd_t c;
    int   s;
    c.op    = op;
    c.sel   = sel[sbms_pkg::SEL_W-1:0];
    c.val   = val;
    c.phase = phase;
    pending_cmds.push_back(c);
    s = sel % NSTK;
    if (op == sbms_pkg::OP_PUSH && gen_used < NCELL) begin
      gen_depth[s]++;
      gen_used++;
    end else if (op == sbms_pkg::OP_POP && gen_depth[s] > 0) begin
      gen_depth[s]--;
      gen_used--;
    end
  endtask

  task automatic add_random(int n, int push_pct, int phase_base);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < push_pct)
        add_cmd(sbms_pkg::OP_PUSH, $urandom_range(3), pick_value(),
                (phase_base + i / 25) % 4);
      else
        add_cmd(sbms_pkg::OP_POP, $urandom_range(3), pick_value(),
                (phase_base + i / 25) % 4);
    end
  endtask

  task automatic add_fill(int phase_base);
    int k;
    k = 0;
    while (gen_used < NCELL) begin
      add_cmd(sbms_pkg::OP_PUSH, $urandom_range(3), pick_value(),
              (phase_base + k / 40) % 4);
      k++;
    end
    // a few more with the pool full
    for (int s = 0; s < NSTK; s++) add_cmd(sbms_pkg::OP_PUSH, s, pick_value(), phase_base);
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || cmd_if.ready) begin
      if (pending_cmds.size() != 0 &&
          $urandom_range(99) >= TX_IDLE_PCT[pending_cmds[0].phase]) begin
        drv_op       <= pending_cmds[0].op;
        drv_sel      <= pending_cmds[0].sel;
        drv_val      <= pending_cmds[0].val;
        rx_stall_pct <= RX_STALL_PCT[pending_cmds[0].phase];
        drv_valid    <= 1'b1;
        void'(pending_cmds.pop_front());
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_accepted >= 100) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
      rx_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // monitor: predict on each accepted command, check each accepted result
  always @(posedge clk_i) begin
    cmd_t    got_cmd;
    result_t want;
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        got_cmd.op    = cmd_if.opcode;
        got_cmd.sel   = cmd_if.stack_sel;
        got_cmd.val   = cmd_if.push_value;
        got_cmd.phase = 0;
        expected_results.push_back(pool_apply(got_cmd));
        n_accepted++;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: value %0d status %0d",
                   $time, res_if.pop_value, res_if.status);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (res_if.pop_value !== want.value) begin
            $display("%0t: pop_value mismatch: expected %0d actual %0d",
                     $time, want.value, res_if.pop_value);
            n_errors++;
          end
          if (res_if.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, res_if.status);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    for (int s = 0; s < NSTK; s++) begin
      head_idx[s]  = '0;
      head_ok[s]   = 1'b0;
      gen_depth[s] = 0;
    end
    for (int i = 0; i < NCELL; i++) begin
      cell_val[i]    = '0;
      cell_nxt[i]    = '0;
      cell_nxt_ok[i] = 1'b0;
      cell_free[i]   = 1'b1;
    end

    // directed: empty pops, extreme values, lifo order per stack
    for (int s = 0; s < NSTK; s++) add_cmd(sbms_pkg::OP_POP, s, '0, 0);
    add_cmd(sbms_pkg::OP_PUSH, 0, 32'sh8000_0000, 0);
    add_cmd(sbms_pkg::OP_PUSH, 1, 32'sh7fff_ffff, 0);
    add_cmd(sbms_pkg::OP_PUSH, 2, '0, 0);
    add_cmd(sbms_pkg::OP_PUSH, 3, -1, 0);
    add_cmd(sbms_pkg::OP_PUSH, 0, 32'sh5555_5555, 0);
    add_cmd(sbms_pkg::OP_PUSH, 1, 32'shaaaa_aaaa, 0);
    add_cmd(sbms_pkg::OP_POP, 0, -1, 0);
    add_cmd(sbms_pkg::OP_POP, 0, '0, 0);
    add_cmd(sbms_pkg::OP_POP, 0, '0, 0);
    add_cmd(sbms_pkg::OP_POP, 1, '0, 0);
    add_cmd(sbms_pkg::OP_POP, 1, '0, 0);
    add_cmd(sbms_pkg::OP_POP, 2, '0, 0);
    add_cmd(sbms_pkg::OP_POP, 3, '0, 0);
    add_cmd(sbms_pkg::OP_PUSH, 2, 1, 0);
    add_cmd(sbms_pkg::OP_PUSH, 2, 2, 0);
    add_cmd(sbms_pkg::OP_POP, 2, '0, 0);
    add_cmd(sbms_pkg::OP_POP, 2, '0, 0);

    // a random mix, then the pool filled to the brim and worked near full
    add_random(40, 70, 0);
    add_fill(1);
    add_random(60, 50, 3);
    add_random(40, 40, 2);

    wait (rst_ni);
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || drv_valid || expected_results.size() != 0);
    repeat (8) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
